@@ src/dff_pkg.sv @@
package dff_pkg;

    localparam int unsigned MAC_W      = 48;
    localparam int unsigned TIME_W     = 64;
    localparam int unsigned SEQ_W      = 12;
    localparam int unsigned WIN_W      = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned VERD_W     = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 5;

    // register map, 8-byte stride
    typedef enum logic [1:0] {
        REG_OWN_BSSID   = 2'd0,
        REG_OWN_ADDRESS = 2'd1,
        REG_AGE_WINDOW  = 2'd2
    } t_reg_idx;

    localparam logic [MAC_W-1:0] OWN_BSSID_RST   = 48'h0001_0203_0405;
    localparam logic [MAC_W-1:0] OWN_ADDRESS_RST = '0;
    localparam logic [WIN_W-1:0] AGE_WINDOW_RST  = 32'd100000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef enum logic [VERD_W-1:0] {
        V_STALE   = 3'd0,
        V_INORDER = 3'd1,
        V_FOREIGN = 3'd2,
        V_SELF    = 3'd3,
        V_DUP     = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [MAC_W-1:0]  addr;
        logic [TIME_W-1:0] stamp;
        logic [SEQ_W-1:0]  seq;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

@@ src/dff_in_if.sv @@
interface dff_in_if import dff_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MAC_W-1:0]  frame_bssid;
    logic [MAC_W-1:0]  source_addr;
    logic [SEQ_W-1:0]  seq_number;
    logic [TIME_W-1:0] rx_time;

    modport source (output valid, frame_bssid, source_addr, seq_number, rx_time, input ready);
    modport sink   (input valid, frame_bssid, source_addr, seq_number, rx_time, output ready);
endinterface

@@ src/dff_out_if.sv @@
interface dff_out_if import dff_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              accept;
    logic [VERD_W-1:0] verdict;
    logic [CNT_W-1:0]  accepted_headers;

    modport source (output valid, accept, verdict, accepted_headers, input ready);
    modport sink   (input valid, accept, verdict, accepted_headers, output ready);
endinterface

@@ src/dff_ram.sv @@
module dff_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/duplicate_frame_filter.sv @@
// Flow: a frame with a foreign BSS id or own source goes from the check state straight to
// the output state; other frames scan the table, then update it, ending early on a hit.
// One frame at a time: no new frame is taken until the last result is taken. The scan
// reads one entry per cycle through a single RAM read port and one shared comparator.
// Reset (synchronous, active low): table marked empty, count zero, registers to defaults.
module duplicate_frame_filter import dff_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    dff_in_if.sink                i_in,
    dff_out_if.source             o_out
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;

    logic [MAC_W-1:0]  r_own_bssid;
    logic [MAC_W-1:0]  r_own_address;
    logic [WIN_W-1:0]  r_age_window;

    logic [MAC_W-1:0]  r_bssid;
    logic [MAC_W-1:0]  r_src;
    logic [SEQ_W-1:0]  r_seq;
    logic [TIME_W-1:0] r_now;

    logic [CNT_W-1:0]  r_count;
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic [IDX_W-1:0]  r_ridx;
    logic              r_issue_done;
    logic              r_cvld;
    logic [IDX_W-1:0]  r_cidx;
    logic              r_vld_d;
    logic [TIME_W-1:0] r_oldest;
    logic [IDX_W-1:0]  r_victim;

    logic [IDX_W-1:0]  r_sel_idx;
    logic [TIME_W-1:0] r_sel_stamp;
    logic [SEQ_W-1:0]  r_sel_seq;

    logic              r_out_accept;
    t_verdict          r_out_verdict;

    // config port
    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = t_reg_idx'(paddr[4:3]);

    always_comb begin
        case (cfg_idx)
            REG_OWN_BSSID:   prdata = CFG_DATA_W'(r_own_bssid);
            REG_OWN_ADDRESS: prdata = CFG_DATA_W'(r_own_address);
            REG_AGE_WINDOW:  prdata = CFG_DATA_W'(r_age_window);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_bssid   <= OWN_BSSID_RST;
            r_own_address <= OWN_ADDRESS_RST;
            r_age_window  <= AGE_WINDOW_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_OWN_BSSID:   r_own_bssid   <= pwdata[MAC_W-1:0];
                REG_OWN_ADDRESS: r_own_address <= pwdata[MAC_W-1:0];
                REG_AGE_WINDOW:  r_age_window  <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // table RAM
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_we;
    t_entry             rd_entry;
    t_entry             wr_entry;

    dff_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_sel_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_ridx),
        .o_rdata (ram_rdata)
    );

    // scan compare: an entry never written reads as all zero
    logic [MAC_W-1:0]  e_addr;
    logic [TIME_W-1:0] e_stamp;
    logic [SEQ_W-1:0]  e_seq;
    logic              scan_hit;
    logic              scan_older;
    logic              scan_last;
    logic [IDX_W-1:0]  miss_idx;

    assign rd_entry   = t_entry'(ram_rdata);
    assign e_addr     = r_vld_d ? rd_entry.addr  : '0;
    assign e_stamp    = r_vld_d ? rd_entry.stamp : '0;
    assign e_seq      = r_vld_d ? rd_entry.seq   : '0;
    assign scan_hit   = r_cvld && (e_addr == r_src);
    assign scan_older = r_cvld && (e_stamp <= r_oldest);
    assign scan_last  = r_cvld && (r_cidx == LAST_IDX);
    assign miss_idx   = scan_older ? r_cidx : r_victim;

    // check and update
    logic              chk_foreign;
    logic              chk_self;
    logic [TIME_W-1:0] gap;
    logic              stale;
    logic [SEQ_W-1:0]  seq_step;
    logic              dup;
    t_verdict          upd_verdict;
    logic [SEQ_W-1:0]  upd_seq;

    assign chk_foreign = (r_bssid != r_own_bssid);
    assign chk_self    = (r_src == r_own_address);
    assign gap         = r_now - r_sel_stamp;
    assign stale       = gap > TIME_W'(r_age_window);
    assign seq_step    = r_seq - r_sel_seq;
    // a step of zero or of half the sequence space or more is a replay
    assign dup         = (seq_step == '0) || seq_step[SEQ_W-1];

    always_comb begin
        if (stale) begin
            upd_verdict = V_STALE;
            upd_seq     = r_seq;
        end else if (dup) begin
            upd_verdict = V_DUP;
            upd_seq     = r_sel_seq;
        end else begin
            upd_verdict = V_INORDER;
            upd_seq     = r_seq;
        end
    end

    assign wr_entry.addr  = r_src;
    assign wr_entry.stamp = r_now;
    assign wr_entry.seq   = upd_seq;
    assign ram_wdata      = wr_entry;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_CHECK;
            S_CHECK:  n_state = (chk_foreign || chk_self) ? S_OUT : S_SCAN;
            S_SCAN:   if (scan_hit || scan_last) n_state = S_UPDATE;
            S_UPDATE: n_state = S_OUT;
            S_OUT:    if (o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        ram_we      = 1'b0;
        case (r_state)
            S_IDLE:   i_in.ready  = 1'b1;
            S_UPDATE: ram_we      = 1'b1;
            S_OUT:    o_out.valid = 1'b1;
            default: ;
        endcase
    end

    assign o_out.accept           = r_out_accept;
    assign o_out.verdict          = r_out_verdict;
    assign o_out.accepted_headers = r_count;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CHECK && !chk_foreign && !chk_self) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_UPDATE) begin
                r_valid[r_sel_idx] <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_bssid <= i_in.frame_bssid;
                    r_src   <= i_in.source_addr;
                    r_seq   <= i_in.seq_number;
                    r_now   <= i_in.rx_time;
                end
            end
            S_CHECK: begin
                r_ridx        <= '0;
                r_issue_done  <= 1'b0;
                r_cvld        <= 1'b0;
                r_oldest      <= '1;
                r_victim      <= '0;
                r_out_accept  <= 1'b0;
                r_out_verdict <= chk_foreign ? V_FOREIGN : V_SELF;
            end
            S_SCAN: begin
                // read issue runs one entry ahead of the compare
                r_cvld  <= !r_issue_done;
                r_cidx  <= r_ridx;
                r_vld_d <= r_valid[r_ridx];
                if (!r_issue_done) begin
                    if (r_ridx == LAST_IDX) begin
                        r_issue_done <= 1'b1;
                    end else begin
                        r_ridx <= r_ridx + 1'b1;
                    end
                end
                if (scan_hit) begin
                    r_sel_idx   <= r_cidx;
                    r_sel_stamp <= e_stamp;
                    r_sel_seq   <= e_seq;
                end else if (scan_last) begin
                    // miss: reuse the oldest entry, last one on ties, as cleared
                    r_sel_idx   <= miss_idx;
                    r_sel_stamp <= '0;
                    r_sel_seq   <= '0;
                end else if (scan_older) begin
                    r_oldest <= e_stamp;
                    r_victim <= r_cidx;
                end
            end
            S_UPDATE: begin
                r_out_accept  <= (upd_verdict == V_STALE) || (upd_verdict == V_INORDER);
                r_out_verdict <= upd_verdict;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_matches_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.accept ==
            ((o_out.verdict == V_STALE) || (o_out.verdict == V_INORDER))))
        else $error("accept flag disagrees with verdict");

    a_count_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("header count moved by more than one");

    a_no_intake_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid || ram_we) |-> !i_in.ready)
        else $error("input ready while a frame is in progress");

    a_dropped_count_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && (chk_foreign || chk_self)) |=> $stable(r_count))
        else $error("dropped frame changed the header count");
`endif

endmodule
